>>> design/tfd_pkg.sv
`default_nettype none

package tfd_pkg;

    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 8;
    localparam int CHAN_W    = 8;
    localparam int PIXFMT_W  = 3;
    localparam int PALFMT_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 3;
    localparam int SLOT_CNT  = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_FORMAT = 1'd1;

    localparam logic [PIXFMT_W-1:0] PIX_ARGB1555 = 3'd0;
    localparam logic [PIXFMT_W-1:0] PIX_RGB565   = 3'd1;
    localparam logic [PIXFMT_W-1:0] PIX_ARGB4444 = 3'd2;
    localparam logic [PIXFMT_W-1:0] PIX_UYVY422  = 3'd3;
    localparam logic [PIXFMT_W-1:0] PIX_PAL4     = 3'd4;
    localparam logic [PIXFMT_W-1:0] PIX_PAL8     = 3'd5;

    localparam logic [PALFMT_W-1:0] COL_ARGB1555 = 2'd0;
    localparam logic [PALFMT_W-1:0] COL_RGB565   = 2'd1;
    localparam logic [PALFMT_W-1:0] COL_ARGB4444 = 2'd2;
    localparam logic [PALFMT_W-1:0] COL_ARGB8888 = 2'd3;

    localparam logic ACT_PAL_WRITE = 1'b0;
    localparam logic ACT_DECODE    = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_texel;

    function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [CHAN_W-1:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic t_texel decode_color(input logic [PALFMT_W-1:0] fmt,
                                            input logic [WORD_W-1:0] w);
        t_texel t;
        unique case (fmt)
            COL_ARGB1555: begin
                t.red   = widen5(w[14:10]);
                t.green = widen5(w[9:5]);
                t.blue  = widen5(w[4:0]);
                t.alpha = w[15] ? CHAN_MAX : '0;
            end
            COL_RGB565: begin
                t.red   = widen5(w[15:11]);
                t.green = widen6(w[10:5]);
                t.blue  = widen5(w[4:0]);
                t.alpha = CHAN_MAX;
            end
            COL_ARGB4444: begin
                t.red   = widen4(w[11:8]);
                t.green = widen4(w[7:4]);
                t.blue  = widen4(w[3:0]);
                t.alpha = widen4(w[15:12]);
            end
            default: begin
                t.red   = w[23:16];
                t.green = w[15:8];
                t.blue  = w[7:0];
                t.alpha = w[31:24];
            end
        endcase
        return t;
    endfunction

    // signed divide by 2**sh, truncating toward zero
    function automatic logic signed [15:0] div_trunc(input logic signed [15:0] x,
                                                     input int unsigned sh);
        logic signed [15:0] bias;
        bias = x[15] ? 16'((1 << sh) - 1) : 16'sd0;
        return (x + bias) >>> sh;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp255(input logic signed [15:0] x);
        if (x < 16'sd0) begin
            return '0;
        end else if (x > 16'sd255) begin
            return CHAN_MAX;
        end
        return x[7:0];
    endfunction

    function automatic t_texel yuv_texel(input logic [7:0] y, input logic [7:0] u8,
                                         input logic [7:0] v8);
        logic signed [15:0] y_s;
        logic signed [15:0] u_s;
        logic signed [15:0] v_s;
        logic signed [15:0] r_s;
        logic signed [15:0] g_s;
        logic signed [15:0] b_s;
        t_texel t;
        y_s = signed'({8'd0, y});
        u_s = signed'({8'd0, u8}) - 16'sd128;
        v_s = signed'({8'd0, v8}) - 16'sd128;
        r_s = y_s + div_trunc(16'sd11 * v_s, 3);
        g_s = y_s - div_trunc(16'sd11 * u_s + 16'sd22 * v_s, 5);
        b_s = y_s + div_trunc(16'sd55 * u_s, 5);
        t.red   = clamp255(r_s);
        t.green = clamp255(g_s);
        t.blue  = clamp255(b_s);
        t.alpha = CHAN_MAX;
        return t;
    endfunction

endpackage

`default_nettype wire

>>> design/tfd_if.sv
`default_nettype none

interface tfd_item_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [tfd_pkg::WORD_W-1:0]  source_word;
    logic [tfd_pkg::SLOT_W-1:0]  palette_slot;

    modport source(output valid, action, source_word, palette_slot, input ready);
    modport sink(input valid, action, source_word, palette_slot, output ready);
endinterface

interface tfd_texel_if;
    logic                        valid;
    logic                        ready;
    logic [tfd_pkg::CHAN_W-1:0]  red;
    logic [tfd_pkg::CHAN_W-1:0]  green;
    logic [tfd_pkg::CHAN_W-1:0]  blue;
    logic [tfd_pkg::CHAN_W-1:0]  alpha;
    logic                        last_texel;

    modport source(output valid, red, green, blue, alpha, last_texel, input ready);
    modport sink(input valid, red, green, blue, alpha, last_texel, output ready);
endinterface

interface tfd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tfd_pkg::CFG_IDX_W-1:0] index;
    logic [tfd_pkg::CFG_DAT_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/tfd_palette_ram.sv
`default_nettype none

module tfd_palette_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [ADDR_W-1:0]          i_wr_addr,
    input  wire logic [tfd_pkg::WORD_W-1:0] i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [ADDR_W-1:0]          i_rd_addr,
    output wire logic [tfd_pkg::WORD_W-1:0] o_rd_data
);

    logic [tfd_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [tfd_pkg::WORD_W-1:0] r_rd_data;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/texel_format_decoder_unit.sv
// Texel format decoder.
// i_item carries one transaction per source word: action 1 decodes the word in the
// current pixel format, action 0 writes it to palette entry palette_slot.
// o_texel carries one transaction per texel in RGBA8888, last_texel on the final one.
// i_cfg writes pixel_format (index 0) and palette_format (index 1); always ready.
// It must be only written while the block is idle; the block does not enforce this.
// Throughput: one texel per cycle from a single issue counter while the output does
// not stall; a word gives 2 texels (16-bit formats, UYVY422), 4 (8-bit palette) or 8
// (4-bit palette). The next word is accepted in the cycle the previous word issues
// its last texel, so words follow without a gap.
// After a word is accepted, its texels pass the issue and palette read stage, then
// the decode into the output register.
// Reset clears the formats to ARGB1555 and empties the pipeline; palette contents
// are undefined until written. When the receiver stalls the output register and
// the read stage hold and the issue counter waits.
`default_nettype none

module texel_format_decoder_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tfd_item_if.sink        i_item,
    tfd_cfg_if.sink         i_cfg,
    tfd_texel_if.source     o_texel
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    logic [tfd_pkg::PIXFMT_W-1:0] r_pixel_format;
    logic [tfd_pkg::PALFMT_W-1:0] r_palette_format;

    logic                         r_busy;
    logic [tfd_pkg::WORD_W-1:0]   r_word;
    logic [2:0]                   r_idx;

    logic                         r_b_valid;
    logic                         r_b_last;
    logic [tfd_pkg::WORD_W-1:0]   r_b_data;

    logic                         r_o_valid;
    tfd_pkg::t_texel              r_o_texel;
    logic                         r_o_last;

    logic [ADDR_W-1:0]            w_wrap [tfd_pkg::SLOT_CNT];
    logic [tfd_pkg::WORD_W-1:0]   w_pal_q;
    logic                         w_c_ready;
    logic                         w_b_adv;
    logic                         w_issue;
    logic                         w_last;
    logic                         w_in_ready;
    logic                         w_accept;
    logic                         w_fmt_ok;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic [tfd_pkg::WORD_W-1:0]   w_b_data;
    tfd_pkg::t_texel              w_texel;

    // index wrap table, resolved at elaboration
    for (genvar g = 0; g < tfd_pkg::SLOT_CNT; g++) begin : g_wrap
        localparam int WRAPPED = g % PALETTE_ENTRIES;
        assign w_wrap[g] = ADDR_W'(WRAPPED);
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format   <= tfd_pkg::PIX_ARGB1555;
            r_palette_format <= tfd_pkg::COL_ARGB1555;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tfd_pkg::CFG_PIXEL_FORMAT:   r_pixel_format   <= i_cfg.data;
                tfd_pkg::CFG_PALETTE_FORMAT: r_palette_format <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    assign w_c_ready = !r_o_valid || o_texel.ready;
    assign w_b_adv   = !r_b_valid || w_c_ready;
    assign w_issue   = r_busy && w_b_adv;

    always_comb begin
        unique case (r_pixel_format)
            tfd_pkg::PIX_PAL4: w_last = (r_idx == 3'd7);
            tfd_pkg::PIX_PAL8: w_last = (r_idx == 3'd3);
            default:           w_last = (r_idx == 3'd1);
        endcase
    end

    assign w_in_ready = !r_busy || (w_issue && w_last);
    assign i_item.ready = w_in_ready;
    assign w_accept = i_item.valid && w_in_ready;

    always_comb begin
        case (r_pixel_format) inside
            tfd_pkg::PIX_ARGB1555, tfd_pkg::PIX_RGB565, tfd_pkg::PIX_ARGB4444,
            tfd_pkg::PIX_UYVY422, tfd_pkg::PIX_PAL4, tfd_pkg::PIX_PAL8: w_fmt_ok = 1'b1;
            default: w_fmt_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            if (w_issue) begin
                r_idx <= r_idx + 3'd1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_accept && i_item.action == tfd_pkg::ACT_DECODE && w_fmt_ok) begin
                r_busy <= 1'b1;
                r_word <= i_item.source_word;
                r_idx  <= 3'd0;
            end
        end
    end

    always_comb begin
        if (r_pixel_format == tfd_pkg::PIX_PAL4) begin
            w_rd_addr = ADDR_W'(r_word[{r_idx, 2'b00} +: 4]);
        end else begin
            w_rd_addr = w_wrap[r_word[{r_idx[1:0], 3'b000} +: 8]];
        end
    end

    tfd_palette_ram #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && i_item.action == tfd_pkg::ACT_PAL_WRITE),
        .i_wr_addr (w_wrap[i_item.palette_slot]),
        .i_wr_data (i_item.source_word),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_pal_q)
    );

    // direct half word, or {y, u, v} for UYVY
    always_comb begin
        if (r_pixel_format == tfd_pkg::PIX_UYVY422) begin
            w_b_data = {8'd0, (r_idx[0] ? r_word[31:24] : r_word[15:8]),
                        r_word[7:0], r_word[23:16]};
        end else begin
            w_b_data = {16'd0, (r_idx[0] ? r_word[31:16] : r_word[15:0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_adv) begin
            r_b_valid <= r_busy;
            r_b_last  <= w_last;
            r_b_data  <= w_b_data;
        end
    end

    always_comb begin
        case (r_pixel_format) inside
            tfd_pkg::PIX_UYVY422:
                w_texel = tfd_pkg::yuv_texel(r_b_data[23:16], r_b_data[15:8],
                                             r_b_data[7:0]);
            tfd_pkg::PIX_PAL4, tfd_pkg::PIX_PAL8:
                w_texel = tfd_pkg::decode_color(r_palette_format, w_pal_q);
            default:
                w_texel = tfd_pkg::decode_color(r_pixel_format[1:0], r_b_data);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_c_ready) begin
            r_o_valid <= r_b_valid;
            r_o_texel <= w_texel;
            r_o_last  <= r_b_last;
        end
    end

    assign o_texel.valid      = r_o_valid;
    assign o_texel.red        = r_o_texel.red;
    assign o_texel.green      = r_o_texel.green;
    assign o_texel.blue       = r_o_texel.blue;
    assign o_texel.alpha      = r_o_texel.alpha;
    assign o_texel.last_texel = r_o_last;

endmodule

`default_nettype wire

>>> verif/texel_format_decoder_unit_tb.sv
`timescale 1ns / 100ps

module texel_format_decoder_unit_tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;

    // pixel format codes the block leaves unused
    localparam logic [tfd_pkg::PIXFMT_W-1:0] PIX_SPARE_LO = 3'd6;
    localparam logic [tfd_pkg::PIXFMT_W-1:0] PIX_SPARE_HI = 3'd7;

    typedef struct packed {
        tfd_pkg::t_texel pix;
        logic            last;
    } t_texel_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tfd_item_if  item_bus();
    tfd_cfg_if   cfg_bus();
    tfd_texel_if texel_bus();

    texel_format_decoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .i_cfg   (cfg_bus),
        .o_texel (texel_bus)
    );

    always #10 i_clk = ~i_clk;

    logic [tfd_pkg::PIXFMT_W-1:0] pix_fmt = tfd_pkg::PIX_ARGB1555;
    logic [tfd_pkg::PALFMT_W-1:0] pal_fmt = tfd_pkg::COL_ARGB1555;
    logic [tfd_pkg::WORD_W-1:0]   palette_mem [tfd_pkg::SLOT_CNT];
    bit                           slot_loaded [tfd_pkg::SLOT_CNT];
    logic [tfd_pkg::SLOT_W-1:0]   loaded_slots [$];
    t_texel_result                expected_texels [$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   burst_left  = 0;
    int   gap_max     = 0;
    int   ready_pct   = 100;
    logic hold_req    = 1'b0;

    function automatic tfd_pkg::t_texel color_texel(
        input logic [tfd_pkg::PALFMT_W-1:0] fmt,
        input logic [tfd_pkg::WORD_W-1:0] w);
        tfd_pkg::t_texel t;
        case (fmt)
            tfd_pkg::COL_ARGB1555: begin
                t.red   = {w[14:10], w[14:12]};
                t.green = {w[9:5], w[9:7]};
                t.blue  = {w[4:0], w[4:2]};
                t.alpha = {8{w[15]}};
            end
            tfd_pkg::COL_RGB565: begin
                t.red   = {w[15:11], w[15:13]};
                t.green = {w[10:5], w[10:9]};
                t.blue  = {w[4:0], w[4:2]};
                t.alpha = 8'hff;
            end
            tfd_pkg::COL_ARGB4444: begin
                t.red   = {2{w[11:8]}};
                t.green = {2{w[7:4]}};
                t.blue  = {2{w[3:0]}};
                t.alpha = {2{w[15:12]}};
            end
            default: begin
                t.red   = w[23:16];
                t.green = w[15:8];
                t.blue  = w[7:0];
                t.alpha = w[31:24];
            end
        endcase
        return t;
    endfunction

    function automatic logic [tfd_pkg::CHAN_W-1:0] sat8(input int x);
        if (x < 0) return 8'd0;
        if (x > 255) return 8'hff;
        return x[7:0];
    endfunction

    // int division truncates toward zero
    function automatic tfd_pkg::t_texel yuv_rgba(input logic [7:0] y8,
                                                 input logic [7:0] u8,
                                                 input logic [7:0] v8);
        int y;
        int u;
        int v;
        tfd_pkg::t_texel t;
        y = int'(y8);
        u = int'(u8) - 128;
        v = int'(v8) - 128;
        t.red   = sat8(y + (11 * v) / 8);
        t.green = sat8(y - (11 * u + 22 * v) / 32);
        t.blue  = sat8(y + (55 * u) / 32);
        t.alpha = 8'hff;
        return t;
    endfunction

    function automatic void predict_texels(input logic act,
                                           input logic [tfd_pkg::WORD_W-1:0] w,
                                           input logic [tfd_pkg::SLOT_W-1:0] slot);
        if (act == tfd_pkg::ACT_PAL_WRITE) begin
            palette_mem[slot] = w;
            if (!slot_loaded[slot]) begin
                slot_loaded[slot] = 1'b1;
                loaded_slots.push_back(slot);
            end
            return;
        end
        case (pix_fmt) inside
            // pixel codes of the 16-bit formats match the palette color codes
            tfd_pkg::PIX_ARGB1555, tfd_pkg::PIX_RGB565, tfd_pkg::PIX_ARGB4444: begin
                expected_texels.push_back('{color_texel(tfd_pkg::PALFMT_W'(pix_fmt),
                                                        {16'd0, w[15:0]}), 1'b0});
                expected_texels.push_back('{color_texel(tfd_pkg::PALFMT_W'(pix_fmt),
                                                        {16'd0, w[31:16]}), 1'b1});
            end
            tfd_pkg::PIX_UYVY422: begin
                expected_texels.push_back('{yuv_rgba(w[15:8], w[7:0], w[23:16]), 1'b0});
                expected_texels.push_back('{yuv_rgba(w[31:24], w[7:0], w[23:16]), 1'b1});
            end
            tfd_pkg::PIX_PAL4: begin
                for (int i = 0; i < 8; i++) begin
                    expected_texels.push_back('{color_texel(pal_fmt,
                                                  palette_mem[{4'd0, w[4*i +: 4]}]),
                                                i == 7});
                end
            end
            tfd_pkg::PIX_PAL8: begin
                for (int i = 0; i < 4; i++) begin
                    expected_texels.push_back('{color_texel(pal_fmt, palette_mem[w[8*i +: 8]]),
                                                i == 3});
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [tfd_pkg::SLOT_W-1:0] pick_loaded_slot();
        return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    task automatic compare_channel(input string name,
                                   input logic [tfd_pkg::CHAN_W-1:0] want,
                                   input logic [tfd_pkg::CHAN_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %02h actual %02h", $time, name, want, got);
            error_count++;
        end
    endtask

    // texel checker
    always @(posedge i_clk) begin
        t_texel_result want;
        if (i_rst_n && texel_bus.valid && texel_bus.ready) begin
            if (expected_texels.size() == 0) begin
                $display("%0t ns: texel with none expected, actual %02h %02h %02h %02h last %0b",
                         $time, texel_bus.red, texel_bus.green, texel_bus.blue,
                         texel_bus.alpha, texel_bus.last_texel);
                error_count++;
            end else begin
                want = expected_texels.pop_front();
                compare_channel("red", want.pix.red, texel_bus.red);
                compare_channel("green", want.pix.green, texel_bus.green);
                compare_channel("blue", want.pix.blue, texel_bus.blue);
                compare_channel("alpha", want.pix.alpha, texel_bus.alpha);
                compare_channel("last_texel", {7'd0, want.last}, {7'd0, texel_bus.last_texel});
            end
        end
    end

    // texel receiver: random runs of ready/stall, plus a long hold-off on request
    initial begin : texel_receiver
        int   run_left;
        int   hold_left;
        logic run_on;
        run_left  = 0;
        hold_left = 0;
        run_on    = 1'b1;
        texel_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                texel_bus.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 8);
                    run_on   = ($urandom_range(0, 99) < ready_pct);
                end
                run_left--;
                texel_bus.ready <= run_on;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [tfd_pkg::WORD_W-1:0] w,
                             input logic [tfd_pkg::SLOT_W-1:0] slot);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0) begin
                item_bus.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
        burst_left--;
        item_bus.valid        <= 1'b1;
        item_bus.action       <= act;
        item_bus.source_word  <= w;
        item_bus.palette_slot <= slot;
        do @(posedge i_clk); while (!item_bus.ready);
        predict_texels(act, w, slot);
    endtask

    // palette writes and ignored decodes leave nothing to wait on, hence the settle time
    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (expected_texels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_formats(input logic [tfd_pkg::PIXFMT_W-1:0] pix,
                               input logic [tfd_pkg::PALFMT_W-1:0] pal);
        wait_idle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= tfd_pkg::CFG_PIXEL_FORMAT;
        cfg_bus.data  <= tfd_pkg::CFG_DAT_W'(pix);
        do @(posedge i_clk); while (!cfg_bus.ready);
        pix_fmt = pix;
        cfg_bus.index <= tfd_pkg::CFG_PALETTE_FORMAT;
        cfg_bus.data  <= tfd_pkg::CFG_DAT_W'(pal);
        do @(posedge i_clk); while (!cfg_bus.ready);
        pal_fmt = pal;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_direct_formats();
        logic [tfd_pkg::PIXFMT_W-1:0] color_fmts [3];
        logic [tfd_pkg::WORD_W-1:0]   color_words [4];
        logic [tfd_pkg::WORD_W-1:0]   yuv_words [5];
        color_fmts  = '{tfd_pkg::PIX_ARGB1555, tfd_pkg::PIX_RGB565, tfd_pkg::PIX_ARGB4444};
        color_words = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_7fff, 32'h5a5a_a5a5};
        // saturation both ways, opposite chroma extremes, neutral gray
        yuv_words   = '{32'h0000_0000, 32'hffff_ffff, 32'hff00_ff00, 32'h00ff_00ff,
                        32'h8080_8080};
        ready_pct <= 100;
        gap_max = 0;
        foreach (color_fmts[f]) begin
            set_formats(color_fmts[f], tfd_pkg::COL_ARGB1555);
            foreach (color_words[i]) send_item(tfd_pkg::ACT_DECODE, color_words[i], '0);
        end
        set_formats(tfd_pkg::PIX_UYVY422, tfd_pkg::COL_ARGB8888);
        foreach (yuv_words[i]) send_item(tfd_pkg::ACT_DECODE, yuv_words[i], '1);
    endtask

    task automatic test_palette_modes();
        logic [tfd_pkg::PALFMT_W-1:0] pal_fmts [4];
        pal_fmts = '{tfd_pkg::COL_ARGB1555, tfd_pkg::COL_RGB565, tfd_pkg::COL_ARGB4444,
                     tfd_pkg::COL_ARGB8888};
        ready_pct <= 70;
        gap_max = 3;
        for (int s = 0; s < 16; s++) begin
            send_item(tfd_pkg::ACT_PAL_WRITE,
                      (s == 0) ? 32'h0 : (s == 15) ? 32'hffff_ffff : 32'($urandom),
                      tfd_pkg::SLOT_W'(s));
        end
        send_item(tfd_pkg::ACT_PAL_WRITE, 32'h8000_7fff, 8'd128);
        send_item(tfd_pkg::ACT_PAL_WRITE, 32'h7fff_8000, 8'd255);
        foreach (pal_fmts[i]) begin
            set_formats(tfd_pkg::PIX_PAL4, pal_fmts[i]);
            send_item(tfd_pkg::ACT_DECODE, 32'h7654_3210, '0);
            send_item(tfd_pkg::ACT_DECODE, 32'hfedc_ba98, '1);
        end
        set_formats(tfd_pkg::PIX_PAL8, tfd_pkg::COL_ARGB8888);
        send_item(tfd_pkg::ACT_DECODE, 32'hff80_0f00, '0);
        set_formats(tfd_pkg::PIX_PAL8, tfd_pkg::COL_ARGB1555);
        send_item(tfd_pkg::ACT_DECODE, 32'h00ff_800f, '0);
    endtask

    // spare formats decode nothing, but palette writes still land
    task automatic test_unused_formats();
        ready_pct <= 100;
        gap_max = 2;
        set_formats(PIX_SPARE_LO, tfd_pkg::COL_ARGB8888);
        send_item(tfd_pkg::ACT_DECODE, 32'hffff_ffff, '1);
        send_item(tfd_pkg::ACT_PAL_WRITE, 32'h9abc_def0, 8'd200);
        set_formats(PIX_SPARE_HI, tfd_pkg::COL_RGB565);
        send_item(tfd_pkg::ACT_DECODE, 32'h1234_5678, '0);
        set_formats(tfd_pkg::PIX_PAL8, tfd_pkg::COL_ARGB8888);
        send_item(tfd_pkg::ACT_DECODE, {4{8'd200}}, '0);
    endtask

    task automatic test_output_backpressure();
        set_formats(tfd_pkg::PIX_PAL4, tfd_pkg::COL_ARGB4444);
        ready_pct <= 100;
        gap_max = 0;
        hold_req <= 1'b1;
        for (int k = 0; k < 20; k++) send_item(tfd_pkg::ACT_DECODE, $urandom, '0);
        wait_idle();
        for (int k = 0; k < 8; k++) send_item(tfd_pkg::ACT_DECODE, $urandom, '0);
    endtask

    task automatic test_random_mix();
        logic [tfd_pkg::PIXFMT_W-1:0] pix;
        logic [tfd_pkg::PALFMT_W-1:0] pal;
        logic [tfd_pkg::WORD_W-1:0]   w;
        int                           n;
        for (int p = 0; p < 16; p++) begin
            pix = tfd_pkg::PIXFMT_W'(p % 8);
            pal = tfd_pkg::PALFMT_W'((p + (p / 8) * 2) % 4);
            set_formats(pix, pal);
            ready_pct <= (p % 3 == 0) ? 100 : (p % 3 == 1) ? 70 : 35;
            gap_max = (p % 4 == 1) ? 0 : $urandom_range(1, 6);
            n = (pix > tfd_pkg::PIX_PAL8) ? 6 : 24;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(tfd_pkg::ACT_PAL_WRITE, $urandom,
                              tfd_pkg::SLOT_W'($urandom_range(0, 255)));
                end else begin
                    if (pix == tfd_pkg::PIX_PAL8) begin
                        w = {pick_loaded_slot(), pick_loaded_slot(),
                             pick_loaded_slot(), pick_loaded_slot()};
                    end else begin
                        w = $urandom;
                    end
                    send_item(tfd_pkg::ACT_DECODE, w,
                              tfd_pkg::SLOT_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.action       = tfd_pkg::ACT_PAL_WRITE;
        item_bus.source_word  = '0;
        item_bus.palette_slot = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = tfd_pkg::CFG_PIXEL_FORMAT;
        cfg_bus.data          = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_direct_formats();
        test_palette_modes();
        test_unused_formats();
        test_output_backpressure();
        test_random_mix();
        wait_idle();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
design/tfd_pkg.sv
design/tfd_if.sv
design/tfd_palette_ram.sv
design/texel_format_decoder_unit.sv
verif/texel_format_decoder_unit_tb.sv
